@@ rtl/shell_script_tokenizer_macros.svh @@
// Assertion macros for the shell script tokenizer.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef SHELL_SCRIPT_TOKENIZER_MACROS_SVH
`define SHELL_SCRIPT_TOKENIZER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Condition a implies condition b in the same cycle.
`define SST_ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("sst: same-cycle check failed");

// Condition a implies condition b in the next cycle.
`define SST_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("sst: next-cycle check failed");

`else

`define SST_ASSERT_IMPL(label, clk, rst_n, a, b)
`define SST_ASSERT_NEXT(label, clk, rst_n, a, b)

`endif

`endif

@@ rtl/sst_pkg.sv @@
// Shared types, constants and helpers for the shell script tokenizer.
// No dependencies.
`default_nettype none

package sst_pkg;

    localparam int OFFSET_BITS = 16;
    localparam int FIELD_W     = 16;
    localparam int FIFO_DEPTH  = 4;
    localparam int PTR_W       = $clog2(FIFO_DEPTH);
    localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);

    typedef logic [OFFSET_BITS-1:0] offset_t;
    localparam offset_t OFFSET_MAX = '1;

    typedef enum logic [3:0] {
        KIND_LIT    = 4'd0,
        KIND_STRING = 4'd1,
        KIND_NUMBER = 4'd2,
        KIND_BOOL   = 4'd3,
        KIND_EQ     = 4'd4,
        KIND_PLUS   = 4'd5,
        KIND_VAR    = 4'd6,
        KIND_ERROR  = 4'd7,
        KIND_END    = 4'd8
    } kind_t;

    // keyword tracker codes: 0 none, 1..4 prefix of "true", 5..9 prefix of "false"
    localparam logic [3:0] KW_NONE      = 4'd0;
    localparam logic [3:0] KW_T         = 4'd1;
    localparam logic [3:0] KW_TRUE_DONE = 4'd4;
    localparam logic [3:0] KW_F         = 4'd5;
    localparam logic [3:0] KW_FALS_DONE = 4'd9;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0a;
    localparam logic [7:0] CH_EQ    = 8'h3d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_L     = 8'h6c;
    localparam logic [7:0] CH_S     = 8'h73;

    typedef struct packed {
        kind_t              kind;
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] len;
        logic               last;
    } entry_t;

    function automatic offset_t sat_inc(input offset_t v);
        return (v == OFFSET_MAX) ? v : offset_t'(v + 1'b1);
    endfunction

    // offsets live in OFFSET_BITS, output fields are 16 bits
    function automatic logic [FIELD_W-1:0] to_field(input offset_t v);
        logic [31:0] w;
        w = 32'(v);
        return w[FIELD_W-1:0];
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
    endfunction

endpackage

`default_nettype wire

@@ rtl/shell_script_tokenizer.sv @@
// Streaming tokenizer for shell-like script text: scanner state plus a small result queue.
// Depends on sst_pkg and shell_script_tokenizer_macros.svh.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------------------
//  text    | in        | text_valid / text_stall   | text_byte, is_end
//  token   | out       | token_valid / token_stall | token_kind, token_start,
//          |           |                           | token_length, last_of_run
//
// One byte per cycle while text_stall is low: the scanner updates its state in the cycle the
// transaction is taken and writes zero, one or two tokens into a four-entry queue; the queue
// drains one token a cycle while token_stall is low.
// text_stall rises when the queue cannot take two more tokens (three or more held).
// Reset returns the scanner to idle at offset zero and empties the queue.
`default_nettype none
`include "shell_script_tokenizer_macros.svh"

module shell_script_tokenizer
    import sst_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               text_valid,
    output      logic               text_stall,
    input  wire logic [7:0]         text_byte,
    input  wire logic               is_end,
    output      logic               token_valid,
    input  wire logic               token_stall,
    output      logic [3:0]         token_kind,
    output      logic [FIELD_W-1:0] token_start,
    output      logic [FIELD_W-1:0] token_length,
    output      logic               last_of_run
);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_LIT,
        MODE_NUM,
        MODE_STR,
        MODE_VAR
    } mode_t;

    mode_t      mode_reg,  mode_next;
    offset_t    start_reg, start_next;
    offset_t    len_reg,   len_next;
    offset_t    pos_reg,   pos_next;
    logic [3:0] kw_reg,    kw_next;
    logic       stop_reg,  stop_next;

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg,    cnt_next;
    entry_t           fifo_mem [FIFO_DEPTH];

    logic    accept;
    logic    pop;
    logic    alnum;
    logic    take_start;
    logic    e_vld, s_vld;
    kind_t   e_kind, s_kind;
    offset_t e_start, s_start;
    offset_t e_len, s_len;
    entry_t  w0, w1;
    logic [1:0] push_cnt;

    function automatic logic [3:0] kw_advance(input logic [3:0] p, input logic [7:0] c);
        logic [3:0] r;
        r = KW_NONE;
        unique case (p)
            4'd1:    if (c == CH_R) r = 4'd2;
            4'd2:    if (c == CH_U) r = 4'd3;
            4'd3:    if (c == CH_E) r = 4'd4;
            4'd5:    if (c == CH_A) r = 4'd6;
            4'd6:    if (c == CH_L) r = 4'd7;
            4'd7:    if (c == CH_S) r = 4'd8;
            4'd8:    if (c == CH_E) r = 4'd9;
            default: r = KW_NONE;
        endcase
        return r;
    endfunction

    assign text_stall = (cnt_reg > CNT_W'(FIFO_DEPTH - 2));
    assign accept     = text_valid && !text_stall;
    assign token_valid = (cnt_reg != '0);
    assign pop        = token_valid && !token_stall;
    assign alnum      = is_alpha(text_byte) || is_digit(text_byte);

    assign token_kind   = fifo_mem[rd_ptr_reg].kind;
    assign token_start  = fifo_mem[rd_ptr_reg].start;
    assign token_length = fifo_mem[rd_ptr_reg].len;
    assign last_of_run  = fifo_mem[rd_ptr_reg].last;

    // scanner: e_* is the token closed by this byte, s_* the one the byte itself makes
    always_comb
    begin
        mode_next  = mode_reg;
        start_next = start_reg;
        len_next   = len_reg;
        pos_next   = pos_reg;
        kw_next    = kw_reg;
        stop_next  = stop_reg;
        take_start = 1'b0;
        e_vld      = 1'b0;
        e_kind     = KIND_LIT;
        e_start    = start_reg;
        e_len      = len_reg;
        s_vld      = 1'b0;
        s_kind     = KIND_END;
        s_start    = pos_reg;
        s_len      = offset_t'(1);
        if (accept)
        begin
            if (is_end)
            begin
                if (!stop_reg)
                begin
                    unique case (mode_reg)
                        MODE_LIT:
                        begin
                            e_vld  = 1'b1;
                            e_kind = KIND_LIT;
                        end
                        MODE_NUM:
                        begin
                            e_vld  = 1'b1;
                            e_kind = KIND_NUMBER;
                        end
                        MODE_STR:
                        begin
                            e_vld  = 1'b1;
                            e_kind = KIND_ERROR;
                        end
                        MODE_VAR:
                        begin
                            e_vld = 1'b1;
                            if (len_reg <= offset_t'(1))
                            begin
                                e_kind = KIND_ERROR;
                                e_len  = offset_t'(1);
                            end
                            else
                            begin
                                e_kind = KIND_VAR;
                            end
                        end
                        default: ;
                    endcase
                end
                s_vld      = 1'b1;
                s_kind     = KIND_END;
                s_len      = '0;
                mode_next  = MODE_IDLE;
                start_next = '0;
                len_next   = '0;
                pos_next   = '0;
                kw_next    = KW_NONE;
                stop_next  = 1'b0;
            end
            else
            begin
                pos_next = sat_inc(pos_reg);
                if (!stop_reg)
                begin
                    if (mode_reg == MODE_STR)
                    begin
                        len_next = sat_inc(len_reg);
                        if (text_byte == CH_QUOTE)
                        begin
                            e_vld     = 1'b1;
                            e_kind    = KIND_STRING;
                            e_len     = sat_inc(len_reg);
                            mode_next = MODE_IDLE;
                        end
                    end
                    else
                    begin
                        take_start = 1'b1;
                        unique case (mode_reg)
                            MODE_LIT:
                            begin
                                if (alnum)
                                begin
                                    len_next   = sat_inc(len_reg);
                                    kw_next    = kw_advance(kw_reg, text_byte);
                                    take_start = 1'b0;
                                end
                                else
                                begin
                                    e_vld = 1'b1;
                                    // keyword only when a space or newline follows it
                                    if ((kw_reg == KW_TRUE_DONE || kw_reg == KW_FALS_DONE) &&
                                        (text_byte == CH_SPACE || text_byte == CH_NL))
                                        e_kind = KIND_BOOL;
                                    else
                                        e_kind = KIND_LIT;
                                    mode_next = MODE_IDLE;
                                end
                            end
                            MODE_NUM:
                            begin
                                if (is_digit(text_byte))
                                begin
                                    len_next   = sat_inc(len_reg);
                                    take_start = 1'b0;
                                end
                                else
                                begin
                                    e_vld     = 1'b1;
                                    e_kind    = KIND_NUMBER;
                                    mode_next = MODE_IDLE;
                                end
                            end
                            MODE_VAR:
                            begin
                                if (alnum)
                                begin
                                    len_next   = sat_inc(len_reg);
                                    take_start = 1'b0;
                                end
                                else if (len_reg <= offset_t'(1))
                                begin
                                    // bare '@': error at the '@', this byte is dropped
                                    e_vld      = 1'b1;
                                    e_kind     = KIND_ERROR;
                                    e_len      = offset_t'(1);
                                    stop_next  = 1'b1;
                                    mode_next  = MODE_IDLE;
                                    take_start = 1'b0;
                                end
                                else
                                begin
                                    e_vld     = 1'b1;
                                    e_kind    = KIND_VAR;
                                    mode_next = MODE_IDLE;
                                end
                            end
                            default: ;
                        endcase
                        if (take_start)
                        begin
                            kw_next = KW_NONE;
                            if (text_byte == CH_SPACE)
                            begin
                            end
                            else if (text_byte == CH_EQ)
                            begin
                                s_vld  = 1'b1;
                                s_kind = KIND_EQ;
                            end
                            else if (text_byte == CH_PLUS)
                            begin
                                s_vld  = 1'b1;
                                s_kind = KIND_PLUS;
                            end
                            else if (is_digit(text_byte))
                            begin
                                mode_next  = MODE_NUM;
                                start_next = pos_reg;
                                len_next   = offset_t'(1);
                            end
                            else if (is_alpha(text_byte))
                            begin
                                mode_next  = MODE_LIT;
                                start_next = pos_reg;
                                len_next   = offset_t'(1);
                                if (text_byte == CH_T)
                                    kw_next = KW_T;
                                else if (text_byte == CH_F)
                                    kw_next = KW_F;
                                else
                                    kw_next = KW_NONE;
                            end
                            else if (text_byte == CH_QUOTE || text_byte == CH_AT)
                            begin
                                mode_next  = (text_byte == CH_QUOTE) ? MODE_STR : MODE_VAR;
                                start_next = pos_reg;
                                len_next   = offset_t'(1);
                            end
                            else
                            begin
                                s_vld     = 1'b1;
                                s_kind    = KIND_ERROR;
                                stop_next = 1'b1;
                            end
                        end
                    end
                end
            end
        end
    end

    // queue write side: closed token first, then the byte's own token
    always_comb
    begin
        w1.kind  = s_kind;
        w1.start = to_field(s_start);
        w1.len   = to_field(s_len);
        w1.last  = 1'b1;
        if (e_vld)
        begin
            w0.kind  = e_kind;
            w0.start = to_field(e_start);
            w0.len   = to_field(e_len);
            w0.last  = !s_vld;
        end
        else
        begin
            w0 = w1;
        end
        push_cnt    = {1'b0, e_vld} + {1'b0, s_vld};
        wr_ptr_next = PTR_W'(wr_ptr_reg + PTR_W'(push_cnt));
        rd_ptr_next = pop ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        cnt_next    = CNT_W'(cnt_reg + CNT_W'(push_cnt) - CNT_W'(pop));
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            fifo_mem[wr_ptr_reg] <= w0;
        if (push_cnt == 2'd2)
            fifo_mem[PTR_W'(wr_ptr_reg + 1'b1)] <= w1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            start_reg  <= '0;
            len_reg    <= '0;
            pos_reg    <= '0;
            kw_reg     <= KW_NONE;
            stop_reg   <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            start_reg  <= start_next;
            len_reg    <= len_next;
            pos_reg    <= pos_next;
            kw_reg     <= kw_next;
            stop_reg   <= stop_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    `SST_ASSERT_IMPL(a_fill_bound, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(FIFO_DEPTH))
    `SST_ASSERT_NEXT(a_end_clears, clk, rst_n, accept && is_end, mode_reg == MODE_IDLE && pos_reg == '0 && !stop_reg)
    `SST_ASSERT_IMPL(a_quiet_after_error, clk, rst_n, accept && !is_end && stop_reg, push_cnt == 2'd0)
    `SST_ASSERT_IMPL(a_end_marker, clk, rst_n, accept && is_end, s_vld && s_kind == KIND_END)
    `SST_ASSERT_IMPL(a_kw_range, clk, rst_n, 1'b1, kw_reg <= KW_FALS_DONE)

endmodule

`default_nettype wire
